@@ hw/rtl/dfsc_pkg.sv @@
// dfsc_pkg: widths, types, state codes and job table for the five-subset census
// no dependencies; every other file of the block imports it

package dfsc_pkg;

	localparam int MaxPoints = 256;
	localparam int CoordBits = 9;
	localparam int IdxW      = $clog2(MaxPoints);
	localparam int CntW      = IdxW + 1;
	localparam int LiftW     = 2 * CoordBits + 2;
	localparam int DiffW     = LiftW + 1;
	localparam int ProdW     = 2 * DiffW + 2;
	localparam int DetW      = 64;
	localparam int TallyW    = 63;
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int NumSlots  = 5;
	localparam int SlotW     = $clog2(NumSlots + 1);
	localparam int NumTerms  = 6;
	localparam int TermW     = $clog2(NumTerms);
	localparam int JobW      = 5;
	localparam int GroupJobs = 4;
	localparam int RankJobs  = 20;

	typedef logic [CoordBits-1:0]    coord_t;
	typedef logic [LiftW-1:0]        lift_t;
	typedef logic signed [DiffW-1:0] diff_t;
	typedef logic [SlotW-1:0]        slot_t;
	typedef logic [1:0]              col_t;
	typedef col_t [2:0]              col3_t;

	localparam col_t ColX = 2'd0;
	localparam col_t ColY = 2'd1;
	localparam col_t ColZ = 2'd2;
	localparam col_t ColW = 2'd3;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		lift_t  w;
	} point_t;

	typedef struct packed {
		point_t pt;
		logic   store;
		logic   last;
		logic   ovf;
	} item_t;

	typedef struct packed {
		logic         start;
		diff_t [8:0]  m;
		diff_t        scale;
	} det_req_t;

	typedef struct packed {
		logic            done;
		logic            zero;
		logic [DetW-1:0] val;
	} det_rsp_t;

	typedef enum logic [2:0] {
		D_IDLE,
		D_PROD,
		D_ACC,
		D_SCALE,
		D_DONE
	} det_state_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_JOB,
		ST_RUN,
		ST_NEXT,
		ST_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		PH_DET,
		PH_FLAT,
		PH_RANK
	} phase_t;

	typedef struct packed {
		slot_t        base;
		slot_t [2:0]  rows;
		col3_t        cols;
		col_t         scol;
		logic         use_scale;
		logic         neg;
	} job_t;

	// the three columns left when one is struck out
	function automatic col3_t cols_without(input col_t c);
		col3_t r;
		case (c)
			ColX: begin
				r[0] = ColY; r[1] = ColZ; r[2] = ColW;
			end
			ColY: begin
				r[0] = ColX; r[1] = ColZ; r[2] = ColW;
			end
			ColZ: begin
				r[0] = ColX; r[1] = ColY; r[2] = ColW;
			end
			default: begin
				r[0] = ColX; r[1] = ColY; r[2] = ColZ;
			end
		endcase
		return r;
	endfunction

	// one 3x3 determinant job: rows are point slots minus the base slot
	function automatic job_t job_desc(input phase_t ph, input logic [JobW-1:0] jidx);
		job_t j;
		col_t c;
		logic [2:0] q;
		j = '0;
		c = jidx[1:0];
		q = jidx[4:2];
		case (ph)
			PH_DET: begin
				j.base = 3'd0;
				j.rows[0] = 3'd1; j.rows[1] = 3'd2; j.rows[2] = 3'd3;
				j.cols = cols_without(c);
				j.scol = c;
				j.use_scale = 1'b1;
				j.neg = ~c[0];
			end
			PH_FLAT: begin
				j.base = 3'd0;
				j.cols[0] = ColX; j.cols[1] = ColY; j.cols[2] = ColZ;
				case (c)
					2'd0: begin
						j.rows[0] = 3'd1; j.rows[1] = 3'd2; j.rows[2] = 3'd3;
					end
					2'd1: begin
						j.rows[0] = 3'd1; j.rows[1] = 3'd2; j.rows[2] = 3'd4;
					end
					2'd2: begin
						j.rows[0] = 3'd1; j.rows[1] = 3'd3; j.rows[2] = 3'd4;
					end
					default: begin
						j.rows[0] = 3'd2; j.rows[1] = 3'd3; j.rows[2] = 3'd4;
					end
				endcase
			end
			default: begin
				j.cols = cols_without(c);
				case (q)
					3'd0: begin
						j.base = 3'd0;
						j.rows[0] = 3'd1; j.rows[1] = 3'd2; j.rows[2] = 3'd3;
					end
					3'd1: begin
						j.base = 3'd0;
						j.rows[0] = 3'd1; j.rows[1] = 3'd2; j.rows[2] = 3'd4;
					end
					3'd2: begin
						j.base = 3'd0;
						j.rows[0] = 3'd1; j.rows[1] = 3'd3; j.rows[2] = 3'd4;
					end
					3'd3: begin
						j.base = 3'd0;
						j.rows[0] = 3'd2; j.rows[1] = 3'd3; j.rows[2] = 3'd4;
					end
					default: begin
						j.base = 3'd1;
						j.rows[0] = 3'd2; j.rows[1] = 3'd3; j.rows[2] = 3'd4;
					end
				endcase
			end
		endcase
		return j;
	endfunction

endpackage

@@ hw/rtl/dfsc_pt_if.sv @@
// dfsc_pt_if: point channel, one lattice point per beat
// depends on dfsc_pkg

interface dfsc_pt_if import dfsc_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;
	logic   last_point;

	modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

@@ hw/rtl/dfsc_res_if.sv @@
// dfsc_res_if: census result channel, one beat per point set
// depends on dfsc_pkg

interface dfsc_res_if import dfsc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CntW-1:0]   points_used;
	logic [TallyW-1:0] count_axis;
	logic [TallyW-1:0] count_plane;
	logic [TallyW-1:0] count_sphere;
	logic [TallyW-1:0] count_sphere_concyclic;
	logic [TallyW-1:0] count_total;
	logic              capacity_overflow;

	modport source (output valid, points_used, count_axis, count_plane, count_sphere,
		count_sphere_concyclic, count_total, capacity_overflow, input ready);
	modport sink   (input valid, points_used, count_axis, count_plane, count_sphere,
		count_sphere_concyclic, count_total, capacity_overflow, output ready);
endinterface

@@ hw/rtl/dfsc_front.sv @@
// dfsc_front: takes point beats, computes the lifted value, decides store or drop
// depends on dfsc_pkg and dfsc_pt_if

module dfsc_front import dfsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dfsc_pt_if.sink     point,
	output item_t       item,
	output logic        push_valid,
	input  logic        push_ready
);

	logic [CntW-1:0] cnt_q;
	logic            ovf_q;
	logic            store;
	logic            take;

	assign store      = cnt_q < CntW'(MaxPoints);
	assign point.ready = push_ready;
	assign push_valid  = point.valid;
	assign take        = point.valid & push_ready;

	always_comb begin
		item.pt.x  = point.coord_x;
		item.pt.y  = point.coord_y;
		item.pt.z  = point.coord_z;
		item.pt.w  = LiftW'(point.coord_x) * LiftW'(point.coord_x)
			+ LiftW'(point.coord_y) * LiftW'(point.coord_y)
			+ LiftW'(point.coord_z) * LiftW'(point.coord_z);
		item.store = store;
		item.last  = point.last_point;
		item.ovf   = ovf_q | ~store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (point.last_point) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (store) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/dfsc_fifo.sv @@
// dfsc_fifo: short queue of classified points between front and back
// depends on dfsc_pkg

module dfsc_fifo import dfsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t push_item,
	input  logic  push_valid,
	output logic  push_ready,
	output item_t pop_item,
	output logic  pop_valid,
	input  logic  pop_ready
);

	item_t                 buf_q [FifoDepth];
	logic [FifoPtrW-1:0]   wr_ptr_q;
	logic [FifoPtrW-1:0]   rd_ptr_q;
	logic [FifoPtrW:0]     fill_q;
	logic                  push;
	logic                  pop;

	assign push_ready = fill_q != (FifoPtrW+1)'(FifoDepth);
	assign pop_valid  = fill_q != '0;
	assign pop_item   = buf_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/dfsc_det3.sv @@
// dfsc_det3: exact 3x3 determinant times a scale, one shared multiplier
// depends on dfsc_pkg

module dfsc_det3 import dfsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  det_req_t req,
	output det_rsp_t rsp
);

	det_state_t                     st_q, st_d;
	logic [TermW-1:0]               term_q;
	diff_t [8:0]                    m_q;
	diff_t                          scale_q;
	logic signed [ProdW-1:0]        prod_q;
	logic [DetW-1:0]                acc_q;
	diff_t                          op1, op2, op3;
	logic signed [ProdW-1:0]        mul_a;
	diff_t                          mul_b;
	logic signed [ProdW+DiffW-1:0]  mul_p;
	logic                           neg;

	// sarrus terms: three positive, then three negative
	always_comb begin
		case (term_q)
			3'd0: begin
				op1 = m_q[0]; op2 = m_q[4]; op3 = m_q[8];
			end
			3'd1: begin
				op1 = m_q[1]; op2 = m_q[5]; op3 = m_q[6];
			end
			3'd2: begin
				op1 = m_q[2]; op2 = m_q[3]; op3 = m_q[7];
			end
			3'd3: begin
				op1 = m_q[2]; op2 = m_q[4]; op3 = m_q[6];
			end
			3'd4: begin
				op1 = m_q[0]; op2 = m_q[5]; op3 = m_q[7];
			end
			default: begin
				op1 = m_q[1]; op2 = m_q[3]; op3 = m_q[8];
			end
		endcase
	end

	assign neg   = term_q >= TermW'(NumTerms / 2);
	assign mul_p = mul_a * mul_b;

	always_comb begin
		st_d = st_q;
		case (st_q)
			D_IDLE:  st_d = req.start ? D_PROD : D_IDLE;
			D_PROD:  st_d = D_ACC;
			D_ACC:   st_d = (term_q == TermW'(NumTerms - 1)) ? D_SCALE : D_PROD;
			D_SCALE: st_d = D_DONE;
			D_DONE:  st_d = D_IDLE;
			default: st_d = D_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			D_PROD: begin
				mul_a = ProdW'(op1);
				mul_b = op2;
			end
			D_ACC: begin
				mul_a = prod_q;
				mul_b = op3;
			end
			D_SCALE: begin
				mul_a = acc_q[ProdW-1:0];
				mul_b = scale_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rsp.done = st_q == D_DONE;
	assign rsp.zero = acc_q == '0;
	assign rsp.val  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			term_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == D_IDLE) begin
				term_q <= '0;
			end else if (st_q == D_ACC) begin
				term_q <= term_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (req.start) begin
					m_q     <= req.m;
					scale_q <= req.scale;
					acc_q   <= '0;
				end
			end
			D_PROD:  prod_q <= mul_p[ProdW-1:0];
			D_ACC:   acc_q <= neg ? acc_q - mul_p[DetW-1:0] : acc_q + mul_p[DetW-1:0];
			D_SCALE: acc_q <= mul_p[DetW-1:0];
			default: acc_q <= acc_q;
		endcase
	end

endmodule

@@ hw/rtl/dfsc_back.sv @@
// dfsc_back: point memory, subset enumeration, classification and result register
// depends on dfsc_pkg, dfsc_res_if and the det_req_t/det_rsp_t link to dfsc_det3

module dfsc_back import dfsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      pop_item,
	input  logic       pop_valid,
	output logic       pop_ready,
	output det_req_t   det_req,
	input  det_rsp_t   det_rsp,
	dfsc_res_if.source census
);

	back_state_t        state_q, state_d;
	point_t             mem [MaxPoints];
	point_t             rd_q;
	logic [IdxW-1:0]    rd_addr;
	logic [CntW-1:0]    wr_cnt_q;
	logic [CntW-1:0]    n_q;
	logic [CntW-1:0]    n_next;
	logic               ovf_q;
	logic [IdxW-1:0]    idx_q [NumSlots];
	logic [IdxW-1:0]    nidx [NumSlots];
	logic [NumSlots-1:0] can;
	logic               more;
	point_t             pv0_q, pv1_q, pv2_q, pv3_q, pv4_q;
	logic [SlotW-1:0]   fcnt_q;
	phase_t             phase_q;
	logic [JobW-1:0]    jidx_q;
	logic [DetW-1:0]    acc_q;
	logic [DetW-1:0]    acc_new;
	logic               allzero_q;
	logic               az;
	logic               last_job;
	logic               stop;
	logic               ax;
	logic [TallyW-1:0]  axis_q, plane_q, sphere_q, conc_q;
	logic               out_valid_q;
	logic               out_free;
	logic               pop;
	job_t               job;
	diff_t              sd;

	logic [CntW-1:0]    res_used_q;
	logic [TallyW-1:0]  res_axis_q, res_plane_q, res_sphere_q, res_conc_q, res_total_q;
	logic               res_ovf_q;

	function automatic point_t pick(input slot_t s, input point_t p0, input point_t p1,
		input point_t p2, input point_t p3, input point_t p4);
		point_t r;
		case (s)
			3'd0:    r = p0;
			3'd1:    r = p1;
			3'd2:    r = p2;
			3'd3:    r = p3;
			default: r = p4;
		endcase
		return r;
	endfunction

	function automatic diff_t comp(input point_t p, input col_t c);
		diff_t v;
		case (c)
			ColX:    v = diff_t'(DiffW'(p.x));
			ColY:    v = diff_t'(DiffW'(p.y));
			ColZ:    v = diff_t'(DiffW'(p.z));
			default: v = diff_t'(DiffW'(p.w));
		endcase
		return v;
	endfunction

	assign pop      = pop_valid & pop_ready;
	assign out_free = ~out_valid_q | census.ready;
	assign n_next   = wr_cnt_q + CntW'(pop_item.store);
	assign job      = job_desc(phase_q, jidx_q);
	assign acc_new  = acc_q + det_rsp.val;
	assign az       = allzero_q & det_rsp.zero;
	assign ax       = (pv0_q.x == pv1_q.x && pv0_q.x == pv2_q.x && pv0_q.x == pv3_q.x
			&& pv0_q.x == pv4_q.x)
		|| (pv0_q.y == pv1_q.y && pv0_q.y == pv2_q.y && pv0_q.y == pv3_q.y
			&& pv0_q.y == pv4_q.y)
		|| (pv0_q.z == pv1_q.z && pv0_q.z == pv2_q.z && pv0_q.z == pv3_q.z
			&& pv0_q.z == pv4_q.z);
	assign sd       = comp(pv4_q, job.scol) - comp(pv0_q, job.scol);

	always_comb begin
		last_job = 1'b0;
		stop     = 1'b0;
		case (phase_q)
			PH_DET: begin
				last_job = jidx_q == JobW'(GroupJobs - 1);
				stop     = (acc_new != '0) | ax;
			end
			PH_FLAT: begin
				last_job = jidx_q == JobW'(GroupJobs - 1);
				stop     = az;
			end
			PH_RANK: begin
				last_job = jidx_q[1:0] == 2'(GroupJobs - 1);
				stop     = az | (jidx_q == JobW'(RankJobs - 1));
			end
			default: begin
				last_job = 1'b0;
				stop     = 1'b0;
			end
		endcase
	end

	// rightmost index that can still move, then the rest follow it
	always_comb begin
		for (int t = 0; t < NumSlots; t++) begin
			can[t]  = (CntW'(idx_q[t]) + CntW'(NumSlots - t)) < n_q;
			nidx[t] = idx_q[t];
		end
		for (int t = 0; t < NumSlots; t++) begin
			if (can[t]) begin
				for (int u = 0; u < NumSlots; u++) begin
					if (u >= t) begin
						nidx[u] = idx_q[t] + IdxW'(u - t + 1);
					end else begin
						nidx[u] = idx_q[u];
					end
				end
			end
		end
		more = |can;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (pop && pop_item.last) begin
					state_d = (n_next >= CntW'(NumSlots)) ? ST_FETCH : ST_OUT;
				end
			end
			ST_FETCH: begin
				if (fcnt_q == SlotW'(NumSlots)) begin
					state_d = ST_JOB;
				end
			end
			ST_JOB:  state_d = ST_RUN;
			ST_RUN: begin
				if (det_rsp.done) begin
					state_d = (last_job && stop) ? ST_NEXT : ST_JOB;
				end
			end
			ST_NEXT: state_d = more ? ST_FETCH : ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		pop_ready     = state_q == ST_LOAD;
		det_req.start = state_q == ST_JOB;
		case (fcnt_q)
			3'd0:    rd_addr = idx_q[0];
			3'd1:    rd_addr = idx_q[1];
			3'd2:    rd_addr = idx_q[2];
			3'd3:    rd_addr = idx_q[3];
			default: rd_addr = idx_q[4];
		endcase
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				det_req.m[3*r+c] = comp(pick(job.rows[r], pv0_q, pv1_q, pv2_q, pv3_q, pv4_q),
					job.cols[c])
					- comp(pick(job.base, pv0_q, pv1_q, pv2_q, pv3_q, pv4_q), job.cols[c]);
			end
		end
		if (job.use_scale) begin
			det_req.scale = job.neg ? -sd : sd;
		end else begin
			det_req.scale = diff_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.store) begin
			mem[wr_cnt_q[IdxW-1:0]] <= pop_item.pt;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			wr_cnt_q    <= '0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			fcnt_q      <= '0;
			phase_q     <= PH_DET;
			jidx_q      <= '0;
			allzero_q   <= 1'b1;
			axis_q      <= '0;
			plane_q     <= '0;
			sphere_q    <= '0;
			conc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && census.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (pop_item.last) begin
							wr_cnt_q <= '0;
							n_q      <= n_next;
							ovf_q    <= pop_item.ovf;
							axis_q   <= '0;
							plane_q  <= '0;
							sphere_q <= '0;
							conc_q   <= '0;
							fcnt_q   <= '0;
						end else if (pop_item.store) begin
							wr_cnt_q <= wr_cnt_q + 1'b1;
						end
					end
				end
				ST_FETCH: begin
					fcnt_q <= fcnt_q + 1'b1;
					if (fcnt_q == SlotW'(NumSlots)) begin
						phase_q   <= PH_DET;
						jidx_q    <= '0;
						allzero_q <= 1'b1;
					end
				end
				ST_RUN: begin
					if (det_rsp.done) begin
						allzero_q <= last_job ? 1'b1 : az;
						if (last_job && phase_q != PH_RANK) begin
							jidx_q <= '0;
						end else begin
							jidx_q <= jidx_q + 1'b1;
						end
						if (last_job) begin
							case (phase_q)
								PH_DET: begin
									if (acc_new == '0) begin
										if (ax) begin
											axis_q <= axis_q + 1'b1;
										end else begin
											phase_q <= PH_FLAT;
										end
									end
								end
								PH_FLAT: begin
									if (az) begin
										plane_q <= plane_q + 1'b1;
									end else begin
										sphere_q <= sphere_q + 1'b1;
										phase_q  <= PH_RANK;
									end
								end
								default: begin
									if (az) begin
										conc_q <= conc_q + 1'b1;
									end
								end
							endcase
						end
					end
				end
				ST_NEXT: fcnt_q <= '0;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (pop && pop_item.last) begin
					for (int t = 0; t < NumSlots; t++) begin
						idx_q[t] <= IdxW'(t);
					end
				end
			end
			ST_FETCH: begin
				case (fcnt_q)
					3'd1:    pv0_q <= rd_q;
					3'd2:    pv1_q <= rd_q;
					3'd3:    pv2_q <= rd_q;
					3'd4:    pv3_q <= rd_q;
					3'd5:    pv4_q <= rd_q;
					default: pv0_q <= pv0_q;
				endcase
				if (fcnt_q == SlotW'(NumSlots)) begin
					acc_q <= '0;
				end
			end
			ST_RUN: begin
				if (det_rsp.done) begin
					acc_q <= acc_new;
				end
			end
			ST_NEXT: begin
				if (more) begin
					for (int t = 0; t < NumSlots; t++) begin
						idx_q[t] <= nidx[t];
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					res_used_q   <= n_q;
					res_axis_q   <= axis_q;
					res_plane_q  <= plane_q;
					res_sphere_q <= sphere_q;
					res_conc_q   <= conc_q;
					res_total_q  <= axis_q + plane_q + sphere_q;
					res_ovf_q    <= ovf_q;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign census.valid                  = out_valid_q;
	assign census.points_used            = res_used_q;
	assign census.count_axis             = res_axis_q;
	assign census.count_plane            = res_plane_q;
	assign census.count_sphere           = res_sphere_q;
	assign census.count_sphere_concyclic = res_conc_q;
	assign census.count_total            = res_total_q;
	assign census.capacity_overflow      = res_ovf_q;

endmodule

@@ hw/rtl/degenerate_five_subset_census.sv @@
// degenerate_five_subset_census: top level, front / queue / back with a determinant unit
// throughput: a point beat is taken each cycle while the 4-deep queue has room; storage stalls
// only while a census runs or waits to hand out its result. census: each 5-subset runs 4 to 28
// 3x3 jobs on the one shared multiplier in dfsc_det3; each point set ends in one result beat.
// reset: asynchronous, clears counters, tallies and flags; the point memory is not cleared

module degenerate_five_subset_census import dfsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dfsc_pt_if.sink    point,
	dfsc_res_if.source census
);

	item_t    push_item;
	logic     push_valid;
	logic     push_ready;
	item_t    pop_item;
	logic     pop_valid;
	logic     pop_ready;
	det_req_t det_req;
	det_rsp_t det_rsp;

	dfsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.item       (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	dfsc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	dfsc_det3 u_det3 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (det_req),
		.rsp    (det_rsp)
	);

	dfsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.det_req   (det_req),
		.det_rsp   (det_rsp),
		.census    (census)
	);

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		census.valid |-> census.count_total
			== TallyW'(census.count_axis + census.count_plane + census.count_sphere))
		else $error("total is not the sum of the classes");

	a_small_set: assert property (@(posedge clk) disable iff (!arst_n)
		(census.valid && census.points_used < CntW'(NumSlots)) |->
			(census.count_total == '0 && census.count_sphere_concyclic == '0))
		else $error("counts from a set of fewer than five points");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		census.valid |-> census.points_used <= CntW'(MaxPoints))
		else $error("points_used beyond capacity");

	a_det_start: assert property (@(posedge clk) disable iff (!arst_n)
		det_req.start |=> !det_req.start)
		else $error("determinant job started twice in a row");

endmodule

@@ dv/degenerate_five_subset_census_test.sv @@
// degenerate_five_subset_census_test: self-checking bench for the five-subset census block
// drives point sets through the point channel and predicts every census result
// depends on dfsc_pkg, dfsc_pt_if, dfsc_res_if and degenerate_five_subset_census
`timescale 1ns / 100ps

module degenerate_five_subset_census_test;
	import dfsc_pkg::*;

	localparam longint CycleLimit = 40000000;

	typedef struct {
		logic [8:0] x;
		logic [8:0] y;
		logic [8:0] z;
		logic       last;
		logic       hold;
		logic       calm;
	} point_beat_t;

	typedef struct {
		logic [8:0]  used;
		logic [62:0] axis;
		logic [62:0] plane;
		logic [62:0] sphere;
		logic [62:0] concyclic;
		logic [62:0] total;
		logic        ovf;
	} census_t;

	logic clk;
	logic arst_n;
	dfsc_pt_if  pt ();
	dfsc_res_if res ();

	degenerate_five_subset_census uut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (pt.sink),
		.census (res.source)
	);

	point_beat_t pending_points[$];
	census_t     expected_census[$];
	int          mismatches = 0;
	longint      cycles = 0;
	logic        calm;

	// predictor state
	longint sx[MaxPoints], sy[MaxPoints], sz[MaxPoints], sw[MaxPoints];
	int     set_count = 0;
	logic   set_ovf = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint det3(longint a0, longint a1, longint a2, longint b0, longint b1,
		longint b2, longint c0, longint c1, longint c2);
		return a0 * (b1 * c2 - b2 * c1) - a1 * (b0 * c2 - b2 * c0) + a2 * (b0 * c1 - b1 * c0);
	endfunction

	function automatic longint coord_of(int p, int c);
		case (c)
			0: return sx[p];
			1: return sy[p];
			2: return sz[p];
			default: return sw[p];
		endcase
	endfunction

	function automatic bit on_axis_plane(int s[5]);
		bit ex, ey, ez;
		ex = 1; ey = 1; ez = 1;
		for (int t = 1; t < 5; t++) begin
			if (sx[s[t]] != sx[s[0]]) ex = 0;
			if (sy[s[t]] != sy[s[0]]) ey = 0;
			if (sz[s[t]] != sz[s[0]]) ez = 0;
		end
		return ex | ey | ez;
	endfunction

	function automatic bit flat_rows(int base, int r0, int r1, int r2, int ncol);
		longint u[3][4];
		int     r[3];
		r[0] = r0; r[1] = r1; r[2] = r2;
		for (int t = 0; t < 3; t++)
			for (int c = 0; c < 4; c++)
				u[t][c] = coord_of(r[t], c) - coord_of(base, c);
		for (int a = 0; a < ncol; a++)
			for (int b = a + 1; b < ncol; b++)
				for (int c = b + 1; c < ncol; c++)
					if (det3(u[0][a], u[0][b], u[0][c], u[1][a], u[1][b], u[1][c],
						u[2][a], u[2][b], u[2][c]) != 0)
						return 0;
		return 1;
	endfunction

	function automatic census_t run_census();
		census_t e;
		int      s[5];
		longint  d;
		bit      cyc;
		e = '{default: '0};
		for (int i = 0; i < set_count; i++)
		for (int j = i + 1; j < set_count; j++)
		for (int k = j + 1; k < set_count; k++)
		for (int l = k + 1; l < set_count; l++)
		for (int m = l + 1; m < set_count; m++) begin
			d = 0;
			// 5x5 lifted determinant along the last row
			for (int c = 0; c < 4; c++) begin
				longint cof;
				longint u[3][3];
				int     q;
				q = 0;
				for (int cc = 0; cc < 4; cc++)
					if (cc != c) begin
						u[0][q] = coord_of(j, cc) - coord_of(i, cc);
						u[1][q] = coord_of(k, cc) - coord_of(i, cc);
						u[2][q] = coord_of(l, cc) - coord_of(i, cc);
						q++;
					end
				cof = det3(u[0][0], u[0][1], u[0][2], u[1][0], u[1][1], u[1][2],
					u[2][0], u[2][1], u[2][2]);
				d += ((c % 2) ? cof : -cof) * (coord_of(m, c) - coord_of(i, c));
			end
			if (d != 0) continue;
			s = '{i, j, k, l, m};
			if (on_axis_plane(s)) e.axis++;
			else if (flat_rows(i, j, k, l, 3) && flat_rows(i, j, k, m, 3) &&
				flat_rows(i, j, l, m, 3) && flat_rows(i, k, l, m, 3)) e.plane++;
			else begin
				e.sphere++;
				cyc = flat_rows(i, j, k, l, 4) || flat_rows(i, j, k, m, 4) ||
					flat_rows(i, j, l, m, 4) || flat_rows(i, k, l, m, 4) ||
					flat_rows(j, k, l, m, 4);
				if (cyc) e.concyclic++;
			end
		end
		e.used  = set_count[8:0];
		e.total = e.axis + e.plane + e.sphere;
		e.ovf   = set_ovf;
		return e;
	endfunction

	task automatic add_point(int x, int y, int z, bit last, bit hold = 0, bit quiet = 0);
		point_beat_t p;
		p.x = x[8:0]; p.y = y[8:0]; p.z = z[8:0];
		p.last = last; p.hold = hold; p.calm = quiet;
		pending_points.push_back(p);
	endtask

	task automatic add_random_set(int n, bit hold, bit quiet);
		int kind, hi, cx, cy, cz, v;
		int vec[30][3];
		int q;
		q = 0;
		for (int a = 0; a < 3; a++) begin
			vec[q] = '{0, 0, 0}; vec[q][a] = 5; q++;
			vec[q] = '{0, 0, 0}; vec[q][a] = -5; q++;
			for (int b = 0; b < 3; b++)
				if (b != a)
					for (int sg = 0; sg < 4; sg++) begin
						vec[q] = '{0, 0, 0};
						vec[q][a] = (sg & 1) ? -3 : 3;
						vec[q][b] = (sg & 2) ? -4 : 4;
						q++;
					end
		end
		kind = $urandom_range(0, 99);
		hi   = kind < 40 ? 2 : kind < 60 ? 5 : 511;
		cx = $urandom_range(5, 506); cy = $urandom_range(5, 506); cz = $urandom_range(5, 506);
		for (int t = 0; t < n; t++) begin
			if (kind >= 80) begin
				v = $urandom_range(0, 29);
				add_point(cx + vec[v][0], cy + vec[v][1], cz + vec[v][2], t == n - 1,
					hold && t == 0, quiet);
			end else
				add_point($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
					t == n - 1, hold && t == 0, quiet);
		end
	endtask

	// predictor: follows every accepted point beat
	always @(posedge clk) begin
		if (arst_n && pt.valid && pt.ready) begin
			if (set_count < MaxPoints) begin
				sx[set_count] = pt.coord_x;
				sy[set_count] = pt.coord_y;
				sz[set_count] = pt.coord_z;
				sw[set_count] = pt.coord_x * pt.coord_x + pt.coord_y * pt.coord_y +
					pt.coord_z * pt.coord_z;
				set_count++;
			end else
				set_ovf = 1'b1;
			if (pt.last_point) begin
				expected_census.push_back(run_census());
				set_count = 0;
				set_ovf   = 1'b0;
			end
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.valid      <= 1'b0;
			pt.coord_x    <= '0;
			pt.coord_y    <= '0;
			pt.coord_z    <= '0;
			pt.last_point <= 1'b0;
			calm          <= 1'b0;
		end else if (!pt.valid || pt.ready) begin
			if (pending_points.size() > 0 &&
				!(pending_points[0].hold && (expected_census.size() != 0 ||
					(pt.valid && pt.ready && pt.last_point))) &&
				(pending_points[0].calm || $urandom_range(0, 99) >= 34)) begin
				pt.valid      <= 1'b1;
				pt.coord_x    <= pending_points[0].x;
				pt.coord_y    <= pending_points[0].y;
				pt.coord_z    <= pending_points[0].z;
				pt.last_point <= pending_points[0].last;
				calm          <= pending_points[0].calm;
				void'(pending_points.pop_front());
			end else
				pt.valid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else begin
			if (res.valid && res.ready) begin
				if (expected_census.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected census beat, points_used %0d", res.points_used);
				end else begin
					census_t e;
					e = expected_census.pop_front();
					if (res.points_used !== e.used || res.count_axis !== e.axis ||
						res.count_plane !== e.plane || res.count_sphere !== e.sphere ||
						res.count_sphere_concyclic !== e.concyclic ||
						res.count_total !== e.total || res.capacity_overflow !== e.ovf) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("census mismatch: exp used %0d axis %0d plane %0d sphere %0d",
								e.used, e.axis, e.plane, e.sphere);
							$display("  exp cyc %0d total %0d ovf %0d",
								e.concyclic, e.total, e.ovf);
							$display("  got used %0d axis %0d plane %0d sphere %0d",
								res.points_used, res.count_axis, res.count_plane,
								res.count_sphere);
							$display("  got cyc %0d total %0d ovf %0d",
								res.count_sphere_concyclic, res.count_total,
								res.capacity_overflow);
						end
					end
				end
			end
			res.ready <= calm || $urandom_range(0, 99) >= 34;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int n, items;
		arst_n     = 1'b0;

		// fewer than five points, extremes of every field
		add_point(511, 511, 511, 1);
		add_point(0, 0, 0, 0);
		add_point(511, 0, 511, 0);
		add_point(0, 511, 0, 1);
		// extremes in a full set
		add_point(0, 0, 0, 0);
		add_point(511, 0, 0, 0);
		add_point(0, 511, 0, 0);
		add_point(0, 0, 511, 0);
		add_point(511, 511, 511, 1);
		// five points on one z plane
		add_point(0, 0, 7, 0); add_point(1, 2, 7, 0); add_point(3, 1, 7, 0);
		add_point(5, 5, 7, 0); add_point(2, 9, 7, 1);
		// slanted plane x+y+z=6
		add_point(0, 0, 6, 0); add_point(1, 2, 3, 0); add_point(2, 2, 2, 0);
		add_point(6, 0, 0, 0); add_point(0, 3, 3, 1);
		// sphere with no four on a circle
		add_point(15, 10, 10, 0); add_point(10, 15, 10, 0); add_point(10, 10, 15, 0);
		add_point(13, 14, 10, 0); add_point(10, 13, 14, 1);
		// sphere with four points on a circle
		add_point(15, 10, 10, 0); add_point(10, 15, 10, 0); add_point(13, 14, 10, 0);
		add_point(14, 13, 10, 0); add_point(10, 10, 15, 1);

		items = pending_points.size();
		for (int s = 0; items < 1850; s++) begin
			n = $urandom_range(0, 99) < 15 ? $urandom_range(1, 4) :
				$urandom_range(0, 99) < 8 ? 9 : $urandom_range(5, 8);
			add_random_set(n, s == 40 || s == 200, s >= 120 && s < 160);
			items += n;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_points.size() == 0);
		@(posedge clk);
		while (pt.valid) @(posedge clk);
		while (expected_census.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
